[sv/isq_pkg.sv]
`default_nettype none

package isq_pkg;

  localparam int DEPTH_DEFAULT = 256;

  localparam int CMD_W     = 4;
  localparam int POS_W     = 9;
  localparam int VAL_W     = 32;
  localparam int ST_W      = 2;
  localparam int CNT_OUT_W = 9;
  localparam int IN_W      = 48;
  localparam int OUT_W     = 48;

  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 4'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 4'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 4'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 4'd3;
  localparam logic [CMD_W-1:0] CMD_FRONT      = 4'd4;
  localparam logic [CMD_W-1:0] CMD_BACK       = 4'd5;
  localparam logic [CMD_W-1:0] CMD_READ_AT    = 4'd6;
  localparam logic [CMD_W-1:0] CMD_INSERT_AT  = 4'd7;
  localparam logic [CMD_W-1:0] CMD_REMOVE_AT  = 4'd8;
  localparam logic [CMD_W-1:0] CMD_CLEAR      = 4'd9;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  // read address select
  localparam logic [1:0] RD_AT     = 2'd0;
  localparam logic [1:0] RD_IDX_DN = 2'd1;
  localparam logic [1:0] RD_IDX_UP = 2'd2;

  typedef struct packed {
    logic            load;
    logic            idx_from_cnt;
    logic            idx_from_at;
    logic            idx_dec;
    logic            idx_inc;
    logic            rd_en;
    logic [1:0]      rd_sel;
    logic            wr_en;
    logic            wr_shift;
    logic            rv_cap;
    logic            cnt_inc;
    logic            cnt_dec;
    logic            cnt_clr;
    logic            st_set;
    logic [ST_W-1:0] st_code;
    logic            res_load;
  } isq_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] op;
    logic             at_gt_cnt;
    logic             at_ge_cnt;
    logic             full;
    logic             idx_gt_at;
    logic             idx_lt_last;
    logic             out_busy;
  } isq_stat_t;

endpackage

`default_nettype wire

[sv/isq_ram.sv]
`default_nettype none

module isq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output      logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[sv/isq_datapath.sv]
`default_nettype none

module isq_datapath import isq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic [CMD_W-1:0]       in_cmd,
  input  wire logic [POS_W-1:0]       in_position,
  input  wire logic signed [VAL_W-1:0] in_item_value,
  input  wire isq_cmd_t               cmd,
  output      isq_stat_t              stat,
  input  wire logic                   out_ready,
  output      logic                   out_valid,
  output      logic [ST_W-1:0]        out_status,
  output      logic signed [VAL_W-1:0] out_read_value,
  output      logic [CNT_OUT_W-1:0]   out_entry_count
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  logic [CMD_W-1:0]        op;
  logic [POS_W-1:0]        pos;
  logic signed [VAL_W-1:0] val;
  logic [CW-1:0]           count;
  logic [CW-1:0]           idx;
  logic signed [VAL_W-1:0] rv;
  logic [ST_W-1:0]         st;

  logic [PW-1:0]    cnt_w;
  logic [PW-1:0]    pos_w;
  logic [PW-1:0]    idx_w;
  logic [PW-1:0]    at_w;
  logic [CW-1:0]    idx_dn;
  logic [CW-1:0]    idx_up;
  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    wr_addr;
  logic [VAL_W-1:0] wr_data;
  logic [VAL_W-1:0] rd_data;

  assign cnt_w  = PW'(count);
  assign pos_w  = PW'(pos);
  assign idx_w  = PW'(idx);
  assign idx_dn = idx - CW'(1);
  assign idx_up = idx + CW'(1);

  // target index of the current command
  always_comb begin
    case (op)
      CMD_PUSH_FRONT, CMD_POP_FRONT, CMD_FRONT: at_w = '0;
      CMD_PUSH_BACK:                            at_w = cnt_w;
      CMD_POP_BACK, CMD_BACK:                   at_w = cnt_w - PW'(1);
      default:                                  at_w = pos_w;
    endcase
  end

  always_comb begin
    stat.op          = op;
    stat.at_gt_cnt   = at_w > cnt_w;
    stat.at_ge_cnt   = at_w >= cnt_w;
    stat.full        = count == CW'(DEPTH);
    stat.idx_gt_at   = idx_w > at_w;
    stat.idx_lt_last = (idx_w + PW'(1)) < cnt_w;
    stat.out_busy    = out_valid && !out_ready;
  end

  always_comb begin
    case (cmd.rd_sel)
      RD_IDX_DN: rd_addr = idx_dn[AW-1:0];
      RD_IDX_UP: rd_addr = idx_up[AW-1:0];
      default:   rd_addr = at_w[AW-1:0];
    endcase
  end

  assign wr_addr = cmd.wr_shift ? idx[AW-1:0] : at_w[AW-1:0];
  assign wr_data = cmd.wr_shift ? rd_data : val;

  isq_ram #(
    .WIDTH(VAL_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (cmd.wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (cmd.rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.cnt_clr) begin
        count <= '0;
      end else if (cmd.cnt_inc) begin
        count <= count + CW'(1);
      end else if (cmd.cnt_dec) begin
        count <= count - CW'(1);
      end
      if (cmd.res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op  <= in_cmd;
      pos <= in_position;
      val <= in_item_value;
      rv  <= '0;
      st  <= ST_OK;
    end else begin
      if (cmd.rv_cap) begin
        rv <= rd_data;
      end
      if (cmd.st_set) begin
        st <= cmd.st_code;
      end
    end
    if (cmd.idx_from_cnt) begin
      idx <= count;
    end else if (cmd.idx_from_at) begin
      idx <= at_w[CW-1:0];
    end else if (cmd.idx_dec) begin
      idx <= idx_dn;
    end else if (cmd.idx_inc) begin
      idx <= idx_up;
    end
    if (cmd.res_load) begin
      out_status      <= st;
      out_read_value  <= rv;
      out_entry_count <= cnt_w[CNT_OUT_W-1:0];
    end
  end

endmodule

`default_nettype wire

[sv/isq_ctrl.sv]
`default_nettype none

module isq_ctrl import isq_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output      logic      in_ready,
  input  wire isq_stat_t stat,
  output      isq_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_SH_RD  = 4'd2;
  localparam logic [3:0] S_SH_WR  = 4'd3;
  localparam logic [3:0] S_RM_CAP = 4'd4;
  localparam logic [3:0] S_RM_RD  = 4'd5;
  localparam logic [3:0] S_RM_WR  = 4'd6;
  localparam logic [3:0] S_RD_CAP = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready = state == S_IDLE;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.op)
          CMD_PUSH_BACK, CMD_PUSH_FRONT, CMD_INSERT_AT: begin
            if (stat.at_gt_cnt) begin
              cmd.st_set  = 1'b1;
              cmd.st_code = ST_RANGE;
              state_next  = S_DONE;
            end else if (stat.full) begin
              cmd.st_set  = 1'b1;
              cmd.st_code = ST_FULL;
              state_next  = S_DONE;
            end else begin
              cmd.idx_from_cnt = 1'b1;
              state_next       = S_SH_RD;
            end
          end
          CMD_POP_FRONT, CMD_POP_BACK, CMD_REMOVE_AT: begin
            if (stat.at_ge_cnt) begin
              cmd.st_set  = 1'b1;
              cmd.st_code = ST_RANGE;
              state_next  = S_DONE;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_AT;
              state_next = S_RM_CAP;
            end
          end
          CMD_FRONT, CMD_BACK, CMD_READ_AT: begin
            if (stat.at_ge_cnt) begin
              cmd.st_set  = 1'b1;
              cmd.st_code = ST_RANGE;
              state_next  = S_DONE;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_AT;
              state_next = S_RD_CAP;
            end
          end
          CMD_CLEAR: begin
            cmd.cnt_clr = 1'b1;
            state_next  = S_DONE;
          end
          default: begin
            cmd.st_set  = 1'b1;
            cmd.st_code = ST_RANGE;
            state_next  = S_DONE;
          end
        endcase
      end
      // move entries up one place, from the back down to the target
      S_SH_RD: begin
        if (stat.idx_gt_at) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_IDX_DN;
          state_next = S_SH_WR;
        end else begin
          cmd.wr_en   = 1'b1;
          cmd.cnt_inc = 1'b1;
          state_next  = S_DONE;
        end
      end
      S_SH_WR: begin
        cmd.wr_en    = 1'b1;
        cmd.wr_shift = 1'b1;
        cmd.idx_dec  = 1'b1;
        state_next   = S_SH_RD;
      end
      S_RM_CAP: begin
        cmd.rv_cap      = 1'b1;
        cmd.idx_from_at = 1'b1;
        state_next      = S_RM_RD;
      end
      // close the gap, moving later entries down one place
      S_RM_RD: begin
        if (stat.idx_lt_last) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_IDX_UP;
          state_next = S_RM_WR;
        end else begin
          cmd.cnt_dec = 1'b1;
          state_next  = S_DONE;
        end
      end
      S_RM_WR: begin
        cmd.wr_en    = 1'b1;
        cmd.wr_shift = 1'b1;
        cmd.idx_inc  = 1'b1;
        state_next   = S_RM_RD;
      end
      S_RD_CAP: begin
        cmd.rv_cap = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

[sv/indexed_sequence_store.sv]
// errors and clear go from decode straight to the result; reads capture the ram word first;
// insert and push front move each entry from the back down to the target up one place,
// and remove and pops move each later entry down one place; each moved entry costs one
// read and one write on the single-port-pair entry ram
// one word in flight: the next word can be taken in the cycle after the result registers
// reset empties the store and the output register; ram contents are not cleared
`default_nettype none

module indexed_sequence_store import isq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output      logic             s_tready,
  input  wire logic [IN_W-1:0]  s_tdata,  // cmd, position, item_value
  output      logic             m_tvalid,
  input  wire logic             m_tready,
  output      logic [OUT_W-1:0] m_tdata   // status, read_value, entry_count
);

  isq_cmd_t  cmd;
  isq_stat_t stat;

  logic [ST_W-1:0]         out_status;
  logic signed [VAL_W-1:0] out_read_value;
  logic [CNT_OUT_W-1:0]    out_entry_count;

  isq_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  isq_datapath #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .in_cmd         (s_tdata[3:0]),
    .in_position    (s_tdata[12:4]),
    .in_item_value  (s_tdata[44:13]),
    .cmd            (cmd),
    .stat           (stat),
    .out_ready      (m_tready),
    .out_valid      (m_tvalid),
    .out_status     (out_status),
    .out_read_value (out_read_value),
    .out_entry_count(out_entry_count)
  );

  assign m_tdata = {5'b0, out_entry_count, out_read_value, out_status};

endmodule

`default_nettype wire

[sv/isq_checker.sv]
`default_nettype none

module isq_checker import isq_pkg::*; (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             s_tvalid,
  input wire logic             s_tready,
  input wire logic [IN_W-1:0]  s_tdata,
  input wire logic             m_tvalid,
  input wire logic             m_tready,
  input wire logic [OUT_W-1:0] m_tdata
);

  logic [ST_W-1:0]  status;
  logic [VAL_W-1:0] read_value;

  assign status     = m_tdata[1:0];
  assign read_value = m_tdata[33:2];

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> status == ST_OK || status == ST_RANGE || status == ST_FULL)
    else $error("bad status code");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && status != ST_OK |-> read_value == '0)
    else $error("nonzero value on error");

  a_one_word: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second word taken while busy");

  a_in_known: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |-> !$isunknown(s_tdata[12:0]))
    else $error("unknown command or position");

endmodule

bind indexed_sequence_store isq_checker u_chk (.*);

`default_nettype wire

[verif/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import isq_pkg::*;

  localparam int STORE_DEPTH = DEPTH_DEFAULT;
  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 12;
  localparam logic [CMD_W-1:0] CMD_LAST_UNUSED = 4'hF;
  localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;
  localparam logic [VAL_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
  localparam logic [VAL_W-1:0] VAL_ALL_ONES = 32'hFFFF_FFFF;
  localparam logic [POS_W-1:0] POS_MAX = 9'h1FF;

  typedef struct {
    logic [ST_W-1:0]      status;
    logic [VAL_W-1:0]     read_value;
    logic [CNT_OUT_W-1:0] entry_count;
  } store_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;  // cmd, position, item_value
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;      // status, read_value, entry_count

  logic [VAL_W-1:0] shadow_list[$];
  store_result_t pending_results[$];

  bit idle_on = 1'b1;
  bit hold_req = 1'b0;
  int words_sent = 0;
  int results_seen = 0;
  int mismatches = 0;
  int ok_hits = 0;
  int range_hits = 0;
  int full_hits = 0;
  int peak_fill = 0;

  always #6 clk = ~clk;

  indexed_sequence_store #(.DEPTH(STORE_DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  function automatic store_result_t apply_command(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                                                  logic [VAL_W-1:0] val);
    store_result_t r;
    int n;
    int at;
    n = shadow_list.size();
    r.status = ST_OK;
    r.read_value = '0;
    case (cmd)
      CMD_PUSH_BACK, CMD_PUSH_FRONT, CMD_INSERT_AT: begin
        if (cmd == CMD_PUSH_BACK) at = n;
        else if (cmd == CMD_PUSH_FRONT) at = 0;
        else at = int'(pos);
        if (at > n) r.status = ST_RANGE;
        else if (n >= STORE_DEPTH) r.status = ST_FULL;
        else shadow_list.insert(at, val);
      end
      CMD_POP_FRONT, CMD_POP_BACK, CMD_FRONT, CMD_BACK: begin
        if (n == 0) begin
          r.status = ST_RANGE;
        end else begin
          at = (cmd == CMD_POP_FRONT || cmd == CMD_FRONT) ? 0 : n - 1;
          r.read_value = shadow_list[at];
          if (cmd == CMD_POP_FRONT || cmd == CMD_POP_BACK) shadow_list.delete(at);
        end
      end
      CMD_READ_AT, CMD_REMOVE_AT: begin
        if (int'(pos) >= n) begin
          r.status = ST_RANGE;
        end else begin
          r.read_value = shadow_list[pos];
          if (cmd == CMD_REMOVE_AT) shadow_list.delete(int'(pos));
        end
      end
      CMD_CLEAR: shadow_list.delete();
      default: r.status = ST_RANGE;
    endcase
    r.entry_count = CNT_OUT_W'(shadow_list.size());
    if (r.status == ST_OK) ok_hits++;
    else if (r.status == ST_RANGE) range_hits++;
    else full_hits++;
    if (shadow_list.size() > peak_fill) peak_fill = shadow_list.size();
    return r;
  endfunction

  function automatic logic [VAL_W-1:0] rand_value();
    logic [VAL_W-1:0] v;
    case ($urandom_range(0, 9))
      0: v = VAL_MIN;
      1: v = VAL_MAX;
      2: v = '0;
      3: v = VAL_ALL_ONES;
      default: v = $urandom();
    endcase
    return v;
  endfunction

  task automatic send_word(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos, logic [VAL_W-1:0] val);
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 13);
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= {3'b000, val, pos, cmd};
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(apply_command(cmd, pos, val));
    words_sent++;
  endtask

  // empty store, every operation, both ends, index limits, unused codes
  task automatic test_directed_ops();
    int c;
    send_word(CMD_POP_FRONT, '0, rand_value());
    send_word(CMD_POP_BACK, '0, rand_value());
    send_word(CMD_FRONT, '0, rand_value());
    send_word(CMD_BACK, '0, rand_value());
    send_word(CMD_READ_AT, '0, rand_value());
    send_word(CMD_REMOVE_AT, '0, rand_value());
    send_word(CMD_INSERT_AT, 9'd1, rand_value());
    for (c = int'(CMD_CLEAR) + 1; c <= int'(CMD_LAST_UNUSED); c++)
      send_word(c[CMD_W-1:0], POS_MAX, VAL_ALL_ONES);
    send_word(CMD_PUSH_BACK, '0, VAL_MAX);
    send_word(CMD_PUSH_FRONT, POS_MAX, VAL_MIN);
    send_word(CMD_INSERT_AT, 9'd0, '0);
    send_word(CMD_INSERT_AT, 9'd3, VAL_ALL_ONES);
    send_word(CMD_INSERT_AT, 9'd2, 32'h1234_5678);
    send_word(CMD_INSERT_AT, POS_MAX, rand_value());
    send_word(CMD_READ_AT, 9'd2, rand_value());
    send_word(CMD_FRONT, '0, rand_value());
    send_word(CMD_BACK, '0, rand_value());
    send_word(CMD_READ_AT, POS_MAX, rand_value());
    send_word(CMD_REMOVE_AT, 9'd1, rand_value());
    send_word(CMD_POP_FRONT, '0, rand_value());
    send_word(CMD_POP_BACK, '0, rand_value());
    send_word(CMD_CLEAR, '0, rand_value());
    send_word(CMD_FRONT, '0, rand_value());
  endtask

  // fill to depth, hit the full and range limits, then drain from both ends
  task automatic test_full_store();
    int k;
    for (k = 0; k < STORE_DEPTH; k++) send_word(CMD_PUSH_BACK, '0, rand_value());
    send_word(CMD_PUSH_BACK, '0, rand_value());
    send_word(CMD_PUSH_FRONT, '0, rand_value());
    send_word(CMD_INSERT_AT, '0, rand_value());
    send_word(CMD_INSERT_AT, 9'd256, rand_value());
    send_word(CMD_INSERT_AT, 9'd257, rand_value());
    send_word(CMD_READ_AT, 9'd255, rand_value());
    send_word(CMD_READ_AT, 9'd256, rand_value());
    send_word(CMD_REMOVE_AT, 9'd255, rand_value());
    send_word(CMD_INSERT_AT, 9'd255, rand_value());
    send_word(CMD_REMOVE_AT, 9'd0, rand_value());
    send_word(CMD_PUSH_FRONT, '0, rand_value());
    send_word(CMD_REMOVE_AT, 9'd128, rand_value());
    send_word(CMD_INSERT_AT, 9'd100, rand_value());
    while (shadow_list.size() > 0)
      send_word(($urandom_range(0, 1) == 0) ? CMD_POP_FRONT : CMD_POP_BACK, '0, rand_value());
    send_word(CMD_POP_BACK, '0, rand_value());
  endtask

  // sink holds off long enough for the input side to stall
  task automatic test_output_stall();
    int k;
    idle_on = 1'b0;
    hold_req = 1'b1;
    for (k = 0; k < 12; k++)
      send_word((k % 3 == 2) ? CMD_BACK : CMD_PUSH_FRONT, '0, rand_value());
    idle_on = 1'b1;
  endtask

  task automatic test_random_mix(int n_words);
    int k;
    int n;
    int roll;
    int fill_goal;
    logic [CMD_W-1:0] cmd;
    logic [POS_W-1:0] pos;
    fill_goal = 32;
    for (k = 0; k < n_words; k++) begin
      n = shadow_list.size();
      if (k % 100 == 0) begin
        fill_goal = ($urandom_range(0, 3) == 0) ? STORE_DEPTH : $urandom_range(0, 120);
        idle_on = ($urandom_range(0, 3) != 0);
      end
      if (k >= n_words - 200) idle_on = 1'b0;
      roll = $urandom_range(0, 99);
      pos = (n > 0) ? POS_W'($urandom_range(0, n - 1)) : '0;
      if (roll < 5) begin
        cmd = CMD_W'($urandom_range(0, 15));
        pos = POS_W'($urandom_range(0, 511));
      end else if (roll < 7) begin
        cmd = CMD_CLEAR;
      end else if (roll < 27) begin
        case ($urandom_range(0, 2))
          0: cmd = CMD_FRONT;
          1: cmd = CMD_BACK;
          default: cmd = CMD_READ_AT;
        endcase
      end else if ((n < fill_goal) == ($urandom_range(0, 3) != 0)) begin
        case ($urandom_range(0, 2))
          0: cmd = CMD_PUSH_BACK;
          1: cmd = CMD_PUSH_FRONT;
          default: begin
            cmd = CMD_INSERT_AT;
            pos = POS_W'($urandom_range(0, n));
          end
        endcase
      end else begin
        case ($urandom_range(0, 2))
          0: cmd = CMD_POP_FRONT;
          1: cmd = CMD_POP_BACK;
          default: cmd = CMD_REMOVE_AT;
        endcase
      end
      if (roll >= 5 && $urandom_range(0, 9) == 0) pos = POS_W'($urandom_range(0, 511));
      send_word(cmd, pos, rand_value());
    end
  endtask

  initial begin : sink_pacing
    int stall;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        m_tready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 13);
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    store_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result word with nothing pending: %h", m_tdata);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[1:0] !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, m_tdata[1:0]);
          mismatches++;
        end
        if (m_tdata[33:2] !== want.read_value) begin
          $error("read_value: expected %0d, actual %0d", $signed(want.read_value),
                 $signed(m_tdata[33:2]));
          mismatches++;
        end
        if (m_tdata[42:34] !== want.entry_count) begin
          $error("entry_count: expected %0d, actual %0d", want.entry_count, m_tdata[42:34]);
          mismatches++;
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    test_directed_ops();
    test_full_store();
    test_output_stall();
    test_random_mix(850);
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("run covered %0d commands and %0d results, peak fill %0d of %0d",
             words_sent, results_seen, peak_fill, STORE_DEPTH);
    $display("outcomes: %0d ok, %0d empty or out of range, %0d full", ok_hits, range_hits,
             full_hits);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[files.f]
sv/isq_pkg.sv
sv/isq_ram.sv
sv/isq_datapath.sv
sv/isq_ctrl.sv
sv/indexed_sequence_store.sv
sv/isq_checker.sv
verif/tb_top.sv
